// ===== sv/b64c_pkg.sv =====
package b64c_pkg;

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } out_item_t;

    // one finished group: up to four result bytes, first in bytes[0]
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
        logic            last;
    } job_t;

    function automatic logic [7:0] enc_char(input logic [5:0] v);
        logic [7:0] c;
        if (v < 6'd26) begin
            c = {2'b00, v} + 8'h41;
        end else if (v < 6'd52) begin
            c = {2'b00, v} + 8'h47;
        end else if (v < 6'd62) begin
            c = {2'b00, v} - 8'd4;
        end else if (v == 6'd62) begin
            c = 8'h2B;
        end else begin
            c = 8'h2F;
        end
        return c;
    endfunction

    // anything outside the alphabet, pad included, gives zero
    function automatic logic [5:0] dec_value(input logic [7:0] c);
        logic [7:0] t;
        t = 8'h00;
        if (c >= 8'h41 && c <= 8'h5A) begin
            t = c - 8'h41;
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            t = c - 8'h47;
        end else if (c >= 8'h30 && c <= 8'h39) begin
            t = c + 8'd4;
        end else if (c == 8'h2B) begin
            t = 8'd62;
        end else if (c == 8'h2F) begin
            t = 8'd63;
        end
        return t[5:0];
    endfunction

endpackage

// ===== sv/b64c_front.sv =====
module b64c_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  b64c_pkg::in_item_t  s_data,
    input  logic                q_full,
    output logic                q_push,
    output b64c_pkg::job_t      q_job
);
    import b64c_pkg::*;

    logic        mode_reg, mode_next;
    logic [23:0] buf_reg, buf_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        pad_reg, pad_next;

    logic        accept;
    logic [7:0]  d;
    logic        lst;
    logic [5:0]  v;
    logic        is_pad;
    logic [23:0] cur_enc;
    logic [23:0] cur_dec;

    assign cfg_ready = 1'b1;
    // no item is taken in a cycle that writes the mode
    assign s_ready   = !q_full && !cfg_valid;
    assign accept    = s_valid && s_ready;
    assign d         = s_data.data_byte;
    assign lst       = s_data.last_byte;
    assign v         = dec_value(d);
    assign is_pad    = (d == PAD_CHAR);

    always_comb begin
        case (cnt_reg)
            2'd0:    cur_enc = buf_reg | {d, 16'h0000};
            2'd1:    cur_enc = buf_reg | {8'h00, d, 8'h00};
            default: cur_enc = buf_reg | {16'h0000, d};
        endcase
    end

    always_comb begin
        case (cnt_reg)
            2'd0:    cur_dec = buf_reg | {v, 18'h0};
            2'd1:    cur_dec = buf_reg | {6'h0, v, 12'h0};
            2'd2:    cur_dec = buf_reg | {12'h0, v, 6'h0};
            default: cur_dec = buf_reg | {18'h0, v};
        endcase
    end

    always_comb begin
        mode_next      = mode_reg;
        buf_next       = buf_reg;
        cnt_next       = cnt_reg;
        pad_next       = pad_reg;
        q_push         = 1'b0;
        q_job.bytes    = '0;
        q_job.last_idx = 2'd3;
        q_job.last     = lst;
        if (cfg_valid && cfg_ready) begin
            mode_next = cfg_data;
            buf_next  = '0;
            cnt_next  = '0;
            pad_next  = 1'b0;
        end else if (accept) begin
            if (!mode_reg) begin
                q_job.bytes[0] = enc_char(cur_enc[23:18]);
                q_job.bytes[1] = enc_char(cur_enc[17:12]);
                q_job.bytes[2] = enc_char(cur_enc[11:6]);
                q_job.bytes[3] = enc_char(cur_enc[5:0]);
                if (cnt_reg == 2'd2) begin
                    q_push   = 1'b1;
                    buf_next = '0;
                    cnt_next = '0;
                end else if (lst) begin
                    // partial group: pad out to four characters
                    q_push = 1'b1;
                    if (cnt_reg == 2'd0) begin
                        q_job.bytes[2] = PAD_CHAR;
                    end
                    q_job.bytes[3] = PAD_CHAR;
                    buf_next = '0;
                    cnt_next = '0;
                end else begin
                    buf_next = cur_enc;
                    cnt_next = cnt_reg + 2'd1;
                end
            end else begin
                q_job.bytes[0] = cur_dec[23:16];
                q_job.bytes[1] = cur_dec[15:8];
                q_job.bytes[2] = cur_dec[7:0];
                if (cnt_reg == 2'd3) begin
                    q_push = 1'b1;
                    if (is_pad) begin
                        q_job.last_idx = pad_reg ? 2'd0 : 2'd1;
                    end else begin
                        q_job.last_idx = 2'd2;
                    end
                    buf_next = '0;
                    cnt_next = '0;
                    pad_next = 1'b0;
                end else if (lst) begin
                    // unfinished group is dropped
                    buf_next = '0;
                    cnt_next = '0;
                    pad_next = 1'b0;
                end else begin
                    buf_next = cur_dec;
                    cnt_next = cnt_reg + 2'd1;
                    if (cnt_reg == 2'd2 && is_pad) begin
                        pad_next = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 1'b0;
            buf_reg  <= '0;
            cnt_reg  <= '0;
            pad_reg  <= 1'b0;
        end else begin
            mode_reg <= mode_next;
            buf_reg  <= buf_next;
            cnt_reg  <= cnt_next;
            pad_reg  <= pad_next;
        end
    end

endmodule

// ===== sv/b64c_queue.sv =====
module b64c_queue #(
    parameter int DEPTH = 2
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  b64c_pkg::job_t  wr_job,
    input  logic            pop,
    output b64c_pkg::job_t  rd_job,
    output logic            q_valid,
    output logic            q_full
);
    import b64c_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    job_t             slots_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    assign q_valid = (count_reg != '0);
    assign q_full  = (count_reg == CW'(DEPTH));
    assign rd_job  = slots_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slots_reg[wr_ptr_reg] <= wr_job;
        end
    end

endmodule

// ===== sv/b64c_back.sv =====
module b64c_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    input  b64c_pkg::job_t      q_job,
    output logic                q_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output b64c_pkg::out_item_t m_data
);
    import b64c_pkg::*;

    logic [1:0] idx_reg, idx_next;
    logic       m_valid_reg, m_valid_next;
    out_item_t  m_data_reg, m_data_next;
    logic       load;
    logic       done;

    assign load    = q_valid && (!m_valid_reg || m_ready);
    assign done    = (idx_reg == q_job.last_idx);
    assign q_pop   = load && done;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        idx_next             = idx_reg;
        m_valid_next         = m_valid_reg;
        m_data_next          = m_data_reg;
        if (load) begin
            m_valid_next         = 1'b1;
            m_data_next.out_byte = q_job.bytes[idx_reg];
            m_data_next.out_last = q_job.last && done;
            idx_next             = done ? 2'd0 : idx_reg + 2'd1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

endmodule

// ===== sv/base64_stream_codec.sv =====
// Streaming base64 codec. With decode_mode at 0 each input item is a raw byte; every third
// byte, or a last_byte flag, yields four characters (partial groups padded with '='). With
// decode_mode at 1 each item is a character; every fourth yields three, two or one bytes
// depending on trailing pads, and a group cut short by last_byte is dropped. The front end
// takes one input item per cycle unless q_full or cfg_valid is high, and hands finished
// groups to a QUEUE_DEPTH-entry queue; the back end emits one result per cycle while
// m_ready allows, from a registered output, so encoding is bounded by the single result
// per cycle of the output and decoding by the input. Results pass a queue slot and then
// the output register. Write decode_mode only while idle; any write clears the group.
module base64_stream_codec #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  b64c_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output b64c_pkg::out_item_t m_data
);
    import b64c_pkg::*;

    logic q_push;
    logic q_pop;
    logic q_valid;
    logic q_full;
    job_t wr_job;
    job_t rd_job;

    b64c_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_job     (wr_job)
    );

    b64c_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wr_job  (wr_job),
        .pop     (q_pop),
        .rd_job  (rd_job),
        .q_valid (q_valid),
        .q_full  (q_full)
    );

    b64c_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_job   (rd_job),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_full)
        else $error("group pushed into full queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("group popped from empty queue");

    a_space_after_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && !q_push) |=> !q_full)
        else $error("queue full right after a pop");

endmodule
